// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/cmdc_pkg.sv
// ----------------------------------------------------------------------------
// Circular maze carver package
// Sequencer states, result kinds and register indexes.
// ----------------------------------------------------------------------------
package cmdc_pkg;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_MARK,
		S_MARK0,
		S_IDLE,
		S_ENTR,
		S_CALC,
		S_SCAN,
		S_MOD,
		S_CARVE,
		S_POP,
		S_POPW,
		S_EXIT
	} state_t;

	localparam logic [1:0] KIND_CARVE    = 2'd0;
	localparam logic [1:0] KIND_ENTRANCE = 2'd1;
	localparam logic [1:0] KIND_EXIT     = 2'd2;

	localparam logic [2:0] CFG_RING_COUNT   = 3'd0;
	localparam logic [2:0] CFG_SUBDIVISION  = 3'd1;
	localparam logic [2:0] CFG_START_MODE   = 3'd2;
	localparam logic [2:0] CFG_START_SECTOR = 3'd3;
	localparam logic [2:0] CFG_EXIT_MODE    = 3'd4;

	localparam logic [1:0] EXIT_CENTER   = 2'd0;
	localparam logic [1:0] EXIT_FARTHEST = 2'd1;

	localparam logic [3:0] RST_RING_COUNT  = 4'd5;
	localparam logic [1:0] RST_SUBDIVISION = 2'd2;

endpackage

// File: hdl/circular_maze_dfs_carver.sv
// ----------------------------------------------------------------------------
// Circular maze carver
// Randomized depth-first carving over a circular grid of rings and sectors.
// ----------------------------------------------------------------------------
// Usage: each input item carries one random value and advances the carve by
// one step. A step emits zero, one or two result items: an entrance opening
// (first step of a perimeter start), one carved wall, or the exit opening in
// the step that empties the path stack. last_of_run marks the final result of a step.
// Input and output use valid/stall; input is taken only when the sequencer
// is idle, results wait in an output register while the receiver stalls.
// Configuration writes to indexes 0 to 4 use cfg_valid/cfg_ready and restart the carve.
// A step that carves reads the visited memory once per neighbor, the neighbor
// count being up to 8 around the center, then takes a bit-serial remainder of
// the 16-bit random value for the random choice. Each backtrack adds a stack
// memory read and a rescan. Reset and every configuration write to a used
// index start a clearing pass over the visited memory, during which no item
// is accepted.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module circular_maze_dfs_carver #(
	parameter int MAX_CELLS  = 256,
	parameter int RING_LIMIT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [6:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] random_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic [7:0]  from_cell,
	output logic [7:0]  to_cell,
	output logic        finished,
	output logic        last_of_run
);

	localparam int CW = $clog2(MAX_CELLS);
	localparam int DW = CW + 1;
	localparam int RW = $clog2(RING_LIMIT + 1);
	localparam int BW = CW + 2 * RW + 4;

	function automatic logic [RW-1:0] lg_of(input logic [RW-1:0] r);
		logic [RW-1:0] l;
		l = '0;
		for (int j = 1; j < RW; j++) begin
			if ((r >> j) != '0) l = RW'(j);
		end
		return l;
	endfunction

	function automatic logic [BW-1:0] sectors_of(input logic [RW-1:0] r, input logic [1:0] f);
		if (r == '0) return BW'(1);
		return BW'(1) << (int'(lg_of(r)) + int'(f));
	endfunction

	// Ring r starts at 1 + 2^f * sum over k < r of 2^floor(log2 k); the sum is
	// taken per power-of-two block of k.
	function automatic logic [BW-1:0] ring_base(input logic [RW-1:0] r, input logic [1:0] f);
		logic [BW-1:0] n;
		logic [BW-1:0] lo;
		logic [BW-1:0] cnt;
		logic [BW-1:0] s;
		if (r == '0) return '0;
		n = BW'(r) - BW'(1);
		s = '0;
		for (int j = 0; j < RW; j++) begin
			lo = BW'(1) << j;
			cnt = '0;
			if (n >= lo) cnt = ((n - lo + BW'(1)) > lo) ? lo : (n - lo + BW'(1));
			s = s + (cnt << j);
		end
		return BW'(1) + (s << f);
	endfunction

	function automatic logic [RW-1:0] rings_eff(input logic [3:0] rc4, input logic [1:0] f);
		logic [RW-1:0] best;
		int rc;
		rc = int'(rc4);
		if (rc < 2) rc = 2;
		if (rc > RING_LIMIT) rc = RING_LIMIT;
		best = RW'(2);
		for (int k = 3; k <= RING_LIMIT; k++) begin
			if (k <= rc && ring_base(RW'(k), f) <= BW'(MAX_CELLS)) best = RW'(k);
		end
		return best;
	endfunction

	function automatic logic [RW-1:0] ring_of(input logic [CW-1:0] cell_idx,
			input logic [RW-1:0] rings, input logic [1:0] f);
		logic [RW-1:0] r;
		if (cell_idx == '0) return '0;
		r = RW'(1);
		for (int k = 2; k < RING_LIMIT; k++) begin
			if (k < int'(rings) && BW'(cell_idx) >= ring_base(RW'(k), f)) r = RW'(k);
		end
		return r;
	endfunction

	// Configuration registers
	logic [3:0] rcount_q;
	logic [1:0] sub_q;
	logic       smode_q;
	logic [6:0] ssector_q;
	logic [1:0] emode_q;

	cmdc_pkg::state_t state_q, state_d;

	logic [CW-1:0] clr_q;
	logic [CW-1:0] cur_q;
	logic [DW-1:0] depth_q;
	logic [DW-1:0] longest_q;
	logic [CW-1:0] lcell_q;
	logic          done_q;
	logic [1:0]    phase_q;
	logic [3:0]    k_q;
	logic [3:0]    cnt_q;
	logic [3:0]    n_q;
	logic          vld_s1;
	logic [3:0]    rem_q;
	logic [3:0]    bit_q;

	logic [15:0]   rv_q;
	logic [CW-1:0] fr_q [8];
	logic [CW-1:0] nb_s1;
	logic [RW-1:0] g_ring_q;
	logic [CW-1:0] g_base_q;
	logic [CW-1:0] g_s_q;
	logic [CW-1:0] g_mask_q;
	logic [CW-1:0] g_pbase_q;
	logic [CW-1:0] g_cbase_q;
	logic          g_half_q;
	logic          g_dbl_q;
	logic          g_center_q;

	logic          out_valid_q;
	logic [1:0]    kind_q;
	logic [7:0]    from_q;
	logic [7:0]    to_q;
	logic          fin_q;
	logic          last_q;

	// Memories
	logic          vis_mem [MAX_CELLS];
	logic [CW-1:0] stk_mem [MAX_CELLS];
	logic          vis_rd_s1;
	logic [CW-1:0] stk_rd_s1;

	logic          vis_we;
	logic [CW-1:0] vis_wa;
	logic          vis_wd;
	logic [CW-1:0] vis_ra;
	logic          stk_we;
	logic [CW-1:0] stk_ra;

	logic [BW-1:0] base_w [RING_LIMIT + 1];
	logic [RW-1:0] rings_w;
	logic [RW-1:0] outer_w;
	logic [CW-1:0] start_w;
	logic [CW-1:0] exit_w;
	logic [CW-1:0] nb_addr_w;
	logic [CW-1:0] nx_w;
	logic [RW-1:0] cur_ring_w;
	logic [RW-1:0] nx_ring_w;
	logic [RW-1:0] target_w;
	logic [BW-1:0] cur_ns_w;

	logic cfg_hit;
	logic in_acc;
	logic slot_free;
	logic emit;
	logic scan_end;
	logic can_carve;
	logic [3:0] rem_sh;

	logic [1:0] e_kind;
	logic [7:0] e_from;
	logic [7:0] e_to;
	logic       e_fin;
	logic       e_last;

	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && cfg_ready && (cfg_index <= cmdc_pkg::CFG_EXIT_MODE);
	assign in_acc    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign scan_end  = (k_q == n_q) && !vld_s1;
	assign can_carve = (cnt_q != '0) && (depth_q < DW'(MAX_CELLS));

	// Geometry derived from the configuration registers
	always_comb begin
		for (int r = 0; r <= RING_LIMIT; r++) begin
			base_w[r] = ring_base(RW'(r), sub_q);
		end
	end

	assign rings_w = rings_eff(rcount_q, sub_q);
	assign outer_w = rings_w - RW'(1);
	assign start_w = smode_q ?
		CW'(base_w[outer_w] + (BW'(ssector_q) & (sectors_of(outer_w, sub_q) - BW'(1)))) : '0;
	assign exit_w = (emode_q[1]) ?
		CW'(base_w[outer_w] + (BW'(rv_q) & (sectors_of(outer_w, sub_q) - BW'(1)))) : lcell_q;

	assign cur_ring_w = ring_of(cur_q, rings_w, sub_q);
	assign cur_ns_w   = sectors_of(cur_ring_w, sub_q);
	assign nx_w       = fr_q[rem_q[2:0]];
	assign nx_ring_w  = ring_of(nx_w, rings_w, sub_q);
	assign target_w   = (emode_q == cmdc_pkg::EXIT_CENTER) ? RW'(1) :
		((emode_q == cmdc_pkg::EXIT_FARTHEST) ? outer_w : '0);

	// Neighbor k of the current cell: left, right, parent, then children; around the center, cell k + 1.
	always_comb begin
		if (g_center_q) begin
			nb_addr_w = CW'(k_q) + CW'(1);
		end else begin
			unique case (k_q)
				4'd0: nb_addr_w = g_base_q + ((g_s_q - CW'(1)) & g_mask_q);
				4'd1: nb_addr_w = g_base_q + ((g_s_q + CW'(1)) & g_mask_q);
				4'd2: begin
					if (g_ring_q == RW'(1)) nb_addr_w = '0;
					else if (g_half_q) nb_addr_w = g_pbase_q + (g_s_q >> 1);
					else nb_addr_w = g_pbase_q + g_s_q;
				end
				4'd3: nb_addr_w = g_dbl_q ? g_cbase_q + (g_s_q << 1) : g_cbase_q + g_s_q;
				default: nb_addr_w = g_cbase_q + (g_s_q << 1) + CW'(1);
			endcase
		end
	end

	assign rem_sh = {rem_q[2:0], rv_q[bit_q]};

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cmdc_pkg::S_CLEAR: begin
				if (clr_q == CW'(MAX_CELLS - 1)) state_d = cmdc_pkg::S_MARK;
			end
			cmdc_pkg::S_MARK: begin
				state_d = (emode_q == cmdc_pkg::EXIT_CENTER) ? cmdc_pkg::S_MARK0 :
					cmdc_pkg::S_IDLE;
			end
			cmdc_pkg::S_MARK0: state_d = cmdc_pkg::S_IDLE;
			cmdc_pkg::S_IDLE: begin
				if (in_acc) begin
					priority if (phase_q[0]) state_d = cmdc_pkg::S_ENTR;
					else if (!done_q) state_d = cmdc_pkg::S_CALC;
					else state_d = cmdc_pkg::S_IDLE;
				end
			end
			cmdc_pkg::S_ENTR: begin
				if (slot_free) state_d = cmdc_pkg::S_CALC;
			end
			cmdc_pkg::S_CALC: state_d = cmdc_pkg::S_SCAN;
			cmdc_pkg::S_SCAN: begin
				if (scan_end) begin
					priority if (can_carve) state_d = cmdc_pkg::S_MOD;
					else if (depth_q == '0) state_d = cmdc_pkg::S_EXIT;
					else state_d = cmdc_pkg::S_POP;
				end
			end
			cmdc_pkg::S_MOD: begin
				if (bit_q == '0) state_d = cmdc_pkg::S_CARVE;
			end
			cmdc_pkg::S_CARVE: begin
				if (slot_free) state_d = cmdc_pkg::S_IDLE;
			end
			cmdc_pkg::S_POP:  state_d = cmdc_pkg::S_POPW;
			cmdc_pkg::S_POPW: state_d = cmdc_pkg::S_CALC;
			cmdc_pkg::S_EXIT: begin
				if (slot_free) state_d = cmdc_pkg::S_IDLE;
			end
			default: state_d = cmdc_pkg::S_CLEAR;
		endcase
		if (cfg_hit) state_d = cmdc_pkg::S_CLEAR;
	end

	// Sequencer outputs
	always_comb begin
		in_stall = (state_q != cmdc_pkg::S_IDLE);
		vis_we   = 1'b0;
		vis_wa   = nx_w;
		vis_wd   = 1'b1;
		stk_we   = 1'b0;
		emit     = 1'b0;
		e_kind   = cmdc_pkg::KIND_CARVE;
		e_from   = 8'(cur_q);
		e_to     = 8'(nx_w);
		e_fin    = 1'b0;
		e_last   = 1'b1;
		unique case (state_q)
			cmdc_pkg::S_CLEAR: begin
				vis_we = 1'b1;
				vis_wa = clr_q;
				vis_wd = 1'b0;
			end
			cmdc_pkg::S_MARK: begin
				vis_we = 1'b1;
				vis_wa = start_w;
			end
			cmdc_pkg::S_MARK0: begin
				vis_we = 1'b1;
				vis_wa = '0;
			end
			cmdc_pkg::S_ENTR: begin
				emit   = slot_free;
				e_kind = cmdc_pkg::KIND_ENTRANCE;
				e_to   = '0;
				e_last = 1'b0;
			end
			cmdc_pkg::S_CARVE: begin
				emit   = slot_free;
				vis_we = slot_free;
				stk_we = slot_free;
			end
			cmdc_pkg::S_EXIT: begin
				emit   = slot_free;
				e_kind = cmdc_pkg::KIND_EXIT;
				e_from = 8'(exit_w);
				e_to   = '0;
				e_fin  = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign vis_ra = nb_addr_w;
	assign stk_ra = depth_q[CW-1:0] - CW'(1);

	always_ff @(posedge clk) begin
		if (vis_we) vis_mem[vis_wa] <= vis_wd;
		vis_rd_s1 <= vis_mem[vis_ra];
	end

	always_ff @(posedge clk) begin
		if (stk_we) stk_mem[depth_q[CW-1:0]] <= cur_q;
		stk_rd_s1 <= stk_mem[stk_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcount_q  <= cmdc_pkg::RST_RING_COUNT;
			sub_q     <= cmdc_pkg::RST_SUBDIVISION;
			smode_q   <= 1'b0;
			ssector_q <= '0;
			emode_q   <= cmdc_pkg::EXIT_CENTER;
		end else if (cfg_hit) begin
			unique case (cfg_index)
				cmdc_pkg::CFG_RING_COUNT:   rcount_q  <= cfg_data[3:0];
				cmdc_pkg::CFG_SUBDIVISION:  sub_q     <= cfg_data[1:0];
				cmdc_pkg::CFG_START_MODE:   smode_q   <= cfg_data[0];
				cmdc_pkg::CFG_START_SECTOR: ssector_q <= cfg_data;
				cmdc_pkg::CFG_EXIT_MODE:    emode_q   <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= cmdc_pkg::S_CLEAR;
			clr_q     <= '0;
			cur_q     <= '0;
			depth_q   <= '0;
			longest_q <= '0;
			lcell_q   <= '0;
			done_q    <= 1'b0;
			phase_q   <= 2'b10;
			k_q       <= '0;
			cnt_q     <= '0;
			vld_s1    <= 1'b0;
			rem_q     <= '0;
			bit_q     <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				cmdc_pkg::S_CLEAR: clr_q <= clr_q + CW'(1);
				cmdc_pkg::S_MARK: begin
					cur_q     <= start_w;
					depth_q   <= '0;
					longest_q <= '0;
					lcell_q   <= '0;
					done_q    <= 1'b0;
					phase_q   <= {1'b1, smode_q};
				end
				cmdc_pkg::S_ENTR: begin
					if (slot_free) phase_q[0] <= 1'b0;
				end
				cmdc_pkg::S_CALC: begin
					k_q    <= '0;
					cnt_q  <= '0;
					vld_s1 <= 1'b0;
				end
				cmdc_pkg::S_SCAN: begin
					if (k_q != n_q) begin
						k_q    <= k_q + 4'd1;
						vld_s1 <= 1'b1;
					end else begin
						vld_s1 <= 1'b0;
					end
					if (vld_s1 && !vis_rd_s1) cnt_q <= cnt_q + 4'd1;
					if (scan_end) begin
						rem_q <= '0;
						bit_q <= 4'd15;
						if (!can_carve && depth_q == '0) done_q <= 1'b1;
					end
				end
				cmdc_pkg::S_MOD: begin
					rem_q <= (rem_sh >= cnt_q) ? rem_sh - cnt_q : rem_sh;
					bit_q <= bit_q - 4'd1;
				end
				cmdc_pkg::S_CARVE: begin
					if (slot_free) begin
						cur_q   <= nx_w;
						depth_q <= depth_q + DW'(1);
						if (target_w != '0 && nx_ring_w == target_w && depth_q > longest_q) begin
							longest_q <= depth_q;
							lcell_q   <= nx_w;
						end
					end
				end
				cmdc_pkg::S_POP:  depth_q <= depth_q - DW'(1);
				cmdc_pkg::S_POPW: cur_q <= stk_rd_s1;
				cmdc_pkg::S_EXIT: begin
					if (slot_free) phase_q[1] <= 1'b0;
				end
				default: begin
				end
			endcase
			if (cfg_hit) clr_q <= '0;
		end
	end

	// Payload registers: step value, free-neighbor list and cell geometry.
	always_ff @(posedge clk) begin
		if (in_acc) rv_q <= random_value;
		if (state_q == cmdc_pkg::S_SCAN) begin
			nb_s1 <= nb_addr_w;
			if (vld_s1 && !vis_rd_s1) fr_q[cnt_q[2:0]] <= nb_s1;
		end
		if (state_q == cmdc_pkg::S_CALC) begin
			g_ring_q   <= cur_ring_w;
			g_center_q <= (cur_q == '0);
			g_base_q   <= CW'(base_w[cur_ring_w]);
			g_s_q      <= cur_q - CW'(base_w[cur_ring_w]);
			g_mask_q   <= CW'(cur_ns_w - BW'(1));
			g_pbase_q  <= (cur_ring_w == '0) ? '0 : CW'(base_w[cur_ring_w - RW'(1)]);
			g_cbase_q  <= CW'(base_w[cur_ring_w + RW'(1)]);
			g_half_q   <= (cur_ring_w >= RW'(2)) &&
				((cur_ring_w & (cur_ring_w - RW'(1))) == '0);
			g_dbl_q    <= (((cur_ring_w + RW'(1)) & cur_ring_w) == '0);
			if (cur_q == '0) begin
				n_q <= 4'(sectors_of(RW'(1), sub_q));
			end else if ((cur_ring_w + RW'(1)) < rings_w) begin
				n_q <= ((((cur_ring_w + RW'(1)) & cur_ring_w) == '0)) ? 4'd5 : 4'd4;
			end else begin
				n_q <= 4'd3;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q <= e_kind;
			from_q <= e_from;
			to_q   <= e_to;
			fin_q  <= e_fin;
			last_q <= e_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = kind_q;
	assign from_cell   = from_q;
	assign to_cell     = to_q;
	assign finished    = fin_q;
	assign last_of_run = last_q;

	`ASSERT_NXT(a_cfg_restart, clk, arst_n, cfg_hit, state_q == cmdc_pkg::S_CLEAR)
	`ASSERT_NXT(a_carve_push, clk, arst_n, state_q == cmdc_pkg::S_CARVE && emit, depth_q == $past(depth_q) + DW'(1))
	`ASSERT_IMP(a_cnt_bound, clk, arst_n, state_q == cmdc_pkg::S_SCAN, cnt_q <= n_q)
	`ASSERT_NXT(a_exit_final, clk, arst_n, state_q == cmdc_pkg::S_EXIT && emit, done_q && !phase_q[1])

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// Circular maze carver testbench
// Runs a series of maze configurations to completion with random step values.
// A local carving predictor builds the expected result items. A monitor
// compares each result against them while both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CELLS = 256;
	localparam int RINGS_MAX = 8;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 200;
	localparam logic [1:0] EXIT_RANDOM = 2'd2;
	localparam logic [2:0] CFG_UNUSED = 3'd7;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] src;
		logic [7:0] dst;
		logic       fin;
		logic       last;
	} carve_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [6:0]  cfg_data;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [15:0] random_value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  result_kind;
	logic [7:0]  from_cell;
	logic [7:0]  to_cell;
	logic        finished;
	logic        last_of_run;

	circular_maze_dfs_carver uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .random_value(random_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_kind(result_kind), .from_cell(from_cell), .to_cell(to_cell),
		.finished(finished), .last_of_run(last_of_run)
	);

	// Predictor state: a private copy of the registers and the carve.
	int unsigned ring_reg, factor_reg, start_mode_reg, start_sector_reg, exit_reg;
	int unsigned rings_used;
	bit          visited[CELLS];
	int unsigned path[CELLS];
	int unsigned depth, here, best_depth, best_cell;
	bit          carve_done;
	bit          entrance_due, exit_due;

	logic [15:0]   step_values[$];
	carve_result_t expected_results[$];
	int unsigned   fail_count = 0;
	int unsigned   cycle_count = 0;
	int unsigned   quiet_cycles = 0;
	logic          in_taken = 1'b0;
	logic          cfg_taken = 1'b0;

	function automatic int unsigned sectors(int unsigned r);
		int unsigned l;
		l = 0;
		if (r == 0)
			return 1;
		while ((r >> (l + 1)) != 0)
			l++;
		return 1 << (l + factor_reg);
	endfunction

	function automatic int unsigned ring_start(int unsigned r);
		int unsigned b;
		b = 1;
		for (int unsigned k = 1; k < r; k++)
			b += sectors(k);
		return b;
	endfunction

	function automatic int unsigned ring_index(int unsigned cell_idx);
		int unsigned r;
		r = 1;
		if (cell_idx == 0)
			return 0;
		while (r + 1 < rings_used && cell_idx >= ring_start(r + 1))
			r++;
		return r;
	endfunction

	function automatic int unsigned list_adjacent(int unsigned cell_idx,
			output int unsigned nb[8]);
		int unsigned n, r, s, ns, base, cb;
		n = 0;
		nb = '{default: 0};
		if (cell_idx == 0) begin
			for (int unsigned k = 0; k < sectors(1); k++)
				nb[n++] = 1 + k;
			return n;
		end
		r = ring_index(cell_idx);
		base = ring_start(r);
		ns = sectors(r);
		s = cell_idx - base;
		nb[n++] = base + (s + ns - 1) % ns;
		nb[n++] = base + (s + 1) % ns;
		if (r == 1)
			nb[n++] = 0;
		else if (ns > sectors(r - 1))
			nb[n++] = ring_start(r - 1) + s / 2;
		else
			nb[n++] = ring_start(r - 1) + s;
		if (r + 1 < rings_used) begin
			cb = ring_start(r + 1);
			if (ns < sectors(r + 1)) begin
				nb[n++] = cb + 2 * s;
				nb[n++] = cb + 2 * s + 1;
			end else begin
				nb[n++] = cb + s;
			end
		end
		return n;
	endfunction

	function automatic void restart_maze();
		int unsigned rc, start;
		rc = ring_reg;
		start = 0;
		if (rc < 2)
			rc = 2;
		if (rc > RINGS_MAX)
			rc = RINGS_MAX;
		rings_used = rc;
		while (rc > 2 && ring_start(rc) > CELLS) begin
			rc--;
			rings_used = rc;
		end
		visited = '{default: 0};
		path = '{default: 0};
		if (start_mode_reg[0])
			start = ring_start(rc - 1) + start_sector_reg % sectors(rc - 1);
		visited[start] = 1;
		if (exit_reg == cmdc_pkg::EXIT_CENTER)
			visited[0] = 1;
		depth = 0;
		here = start;
		best_depth = 0;
		best_cell = 0;
		carve_done = 0;
		entrance_due = start_mode_reg[0];
		exit_due = 1;
	endfunction

	function automatic void write_model_reg(logic [2:0] idx, logic [6:0] data);
		case (idx)
			cmdc_pkg::CFG_RING_COUNT:   ring_reg = data[3:0];
			cmdc_pkg::CFG_SUBDIVISION:  factor_reg = data[1:0];
			cmdc_pkg::CFG_START_MODE:   start_mode_reg = data[0];
			cmdc_pkg::CFG_START_SECTOR: start_sector_reg = data;
			cmdc_pkg::CFG_EXIT_MODE:    exit_reg = data[1:0];
			default: return;
		endcase
		restart_maze();
	endfunction

	function automatic void push_result(logic [1:0] kind, int unsigned src,
			int unsigned dst);
		carve_result_t e;
		e.kind = kind;
		e.src = src[7:0];
		e.dst = dst[7:0];
		e.fin = carve_done;
		e.last = 0;
		expected_results.push_back(e);
	endfunction

	// One step of the carve; the results it causes go to expected_results.
	function automatic void carve_step(logic [15:0] rv);
		int unsigned nb[8];
		int unsigned free_cells[8];
		int unsigned n, c, nx, target, src, first;
		first = expected_results.size();
		if (entrance_due) begin
			push_result(cmdc_pkg::KIND_ENTRANCE, here, 0);
			entrance_due = 0;
		end
		while (!carve_done) begin
			n = list_adjacent(here, nb);
			c = 0;
			for (int unsigned i = 0; i < n; i++)
				if (nb[i] < CELLS && !visited[nb[i]])
					free_cells[c++] = nb[i];
			if (c > 0 && depth < CELLS) begin
				nx = free_cells[rv % c];
				visited[nx] = 1;
				path[depth++] = here;
				push_result(cmdc_pkg::KIND_CARVE, here, nx);
				here = nx;
				target = (exit_reg == cmdc_pkg::EXIT_CENTER) ? 1 :
					(exit_reg == cmdc_pkg::EXIT_FARTHEST ? rings_used - 1 : 0);
				if (target != 0 && ring_index(nx) == target && depth - 1 > best_depth) begin
					best_depth = depth - 1;
					best_cell = nx;
				end
				break;
			end
			if (depth == 0) begin
				carve_done = 1;
				break;
			end
			here = path[--depth];
		end
		if (carve_done && exit_due) begin
			src = best_cell;
			if (exit_reg >= EXIT_RANDOM)
				src = ring_start(rings_used - 1) + rv % sectors(rings_used - 1);
			push_result(cmdc_pkg::KIND_EXIT, src, 0);
			exit_due = 0;
		end
		if (expected_results.size() > first)
			expected_results[expected_results.size() - 1].last = 1;
	endfunction

	// Idling is switched off for one long stretch in the middle of the run.
	function automatic bit take_break();
		if (cycle_count > 4000 && cycle_count < 12000)
			return 0;
		return $urandom_range(99) < 31;
	endfunction

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		in_taken <= in_valid && !in_stall;
		cfg_taken <= cfg_valid && cfg_ready;
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
		if (arst_n && in_valid && !in_stall)
			carve_step(random_value);
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("result item with nothing expected: kind %0d from %0d to %0d",
					result_kind, from_cell, to_cell);
				fail_count++;
			end else begin
				carve_result_t e;
				e = expected_results.pop_front();
				if (result_kind !== e.kind) begin
					$error("result_kind expected %0d actual %0d", e.kind, result_kind);
					fail_count++;
				end
				if (from_cell !== e.src) begin
					$error("from_cell expected %0d actual %0d", e.src, from_cell);
					fail_count++;
				end
				if (to_cell !== e.dst) begin
					$error("to_cell expected %0d actual %0d", e.dst, to_cell);
					fail_count++;
				end
				if (finished !== e.fin) begin
					$error("finished expected %0d actual %0d", e.fin, finished);
					fail_count++;
				end
				if (last_of_run !== e.last) begin
					$error("last_of_run expected %0d actual %0d", e.last, last_of_run);
					fail_count++;
				end
			end
		end
	end

	// Step driver: a new item goes out once the previous one was taken.
	always @(negedge clk) begin
		out_stall <= arst_n ? take_break() : 1'b0;
		if (arst_n && (!in_valid || in_taken)) begin
			if (step_values.size() > 0 && !take_break()) begin
				random_value <= step_values.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [6:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(negedge clk);
		while (!cfg_taken);
		cfg_valid <= 1'b0;
		write_model_reg(idx, data);
	endtask

	task automatic wait_idle();
		wait (step_values.size() == 0 && expected_results.size() == 0);
		@(negedge clk);
		wait (!in_valid && expected_results.size() == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Writes all five registers, with random spare upper bits in the narrow
	// fields, then queues enough steps to finish the maze plus a few that cause nothing.
	task automatic run_maze(input int unsigned rc, input int unsigned sf,
			input int unsigned sm, input int unsigned ss, input int unsigned em,
			input int unsigned extra, inout int unsigned issued);
		int unsigned steps;
		wait_idle();
		write_reg(cmdc_pkg::CFG_RING_COUNT, {3'($urandom_range(7)), rc[3:0]});
		write_reg(cmdc_pkg::CFG_SUBDIVISION, {5'($urandom_range(31)), sf[1:0]});
		write_reg(cmdc_pkg::CFG_START_MODE, {6'($urandom_range(63)), sm[0]});
		write_reg(cmdc_pkg::CFG_START_SECTOR, ss[6:0]);
		write_reg(cmdc_pkg::CFG_EXIT_MODE, {5'($urandom_range(31)), em[1:0]});
		steps = ring_start(rings_used) + extra;
		for (int unsigned i = 0; i < steps; i++)
			step_values.push_back($urandom);
		issued += steps;
	endtask

	initial begin
		int unsigned issued;
		issued = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		ring_reg = cmdc_pkg::RST_RING_COUNT;
		factor_reg = cmdc_pkg::RST_SUBDIVISION;
		start_mode_reg = 0;
		start_sector_reg = 0;
		exit_reg = cmdc_pkg::EXIT_CENTER;
		restart_maze();
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Reset configuration first, with the extreme step values up front.
		step_values.push_back(16'h0000);
		step_values.push_back(16'hFFFF);
		for (int unsigned i = 0; i < 4; i++)
			step_values.push_back($urandom);
		issued = 6;
		wait_idle();
		// A write to an unused index must change nothing.
		write_reg(CFG_UNUSED, 7'h7F);
		for (int unsigned i = 0; i < ring_start(rings_used); i++)
			step_values.push_back($urandom);
		issued += ring_start(rings_used);

		// Clamped ring counts, all factors, both starts and every exit mode.
		run_maze(0, 0, 0, 0, cmdc_pkg::EXIT_CENTER, 2, issued);
		run_maze(15, 3, 1, 127, cmdc_pkg::EXIT_FARTHEST, 2, issued);
		run_maze(8, 3, 1, 5, EXIT_RANDOM, 2, issued);
		run_maze(2, 0, 1, 3, 3, 2, issued);
		run_maze(2, 1, 0, 0, cmdc_pkg::EXIT_FARTHEST, 2, issued);
		run_maze(1, 2, 1, 64, cmdc_pkg::EXIT_CENTER, 2, issued);

		while (issued < 1600)
			run_maze($urandom_range(15), $urandom_range(3), $urandom_range(1),
				$urandom_range(127), $urandom_range(3), $urandom_range(4), issued);

		wait_idle();
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
